// ===== rtl/core/nec_ir_edge_interval_decoder_defines.svh =====
// Assertion macros used by the NEC IR decoder back end.
`ifndef NEC_IR_EDGE_INTERVAL_DECODER_DEFINES_SVH
`define NEC_IR_EDGE_INTERVAL_DECODER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define NECIR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define NECIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/necir_pkg.sv =====
// Types and constants of the NEC IR edge interval decoder.
package necir_pkg;

  localparam logic [15:0] HOLD_LOW   = 16'd9500;
  localparam logic [15:0] HOLD_HIGH  = 16'd10300;
  localparam int          FRAME_BITS = 32;
  localparam int          CNT_W      = $clog2(FRAME_BITS);

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_FRAME  = 2'd1;
  localparam logic [1:0] EV_REPEAT = 2'd2;
  localparam logic [1:0] EV_ABORT  = 2'd3;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_MAX    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESH = 3'd6;

  typedef struct packed {
    logic [15:0] interval;
    logic [15:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [31:0] frame_word;
    logic [15:0] hold_count;
    logic [15:0] hold_time;
  } out_item_t;

  typedef struct packed {
    logic hold_hit;
    logic start_hit;
    logic repeat_hit;
    logic bit_bad;
    logic one_bit;
  } edge_class_t;

  typedef struct packed {
    edge_class_t cls;
    logic [15:0] timestamp;
  } qent_t;

endpackage

// ===== rtl/core/nec_ir_edge_interval_decoder.sv =====
// Top level of the NEC IR edge interval decoder.
// Each input item is one falling edge of the IR receiver (interval in 10 us ticks and a
// timestamp); each item yields exactly one result item carrying an event code (none, frame
// complete, repeat, abort), the 32-bit frame word on frame completion, and the hold-gap
// counter and timestamp. One item is accepted per clock cycle while the queue has room;
// when the output is stalled the queue fills and in_ready drops. The front end compares
// the interval against the configured windows in the accept cycle, a two-entry queue holds
// classified edges, and the back end pops each one, updates the frame state and writes the
// result into an output register that holds it until it is taken.
// Configuration writes are taken every cycle and should be issued only while no edge is in
// flight.
module nec_ir_edge_interval_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [necir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  necir_pkg::in_item_t             in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output necir_pkg::out_item_t            out_item
);
  import necir_pkg::*;

  logic  push;
  logic  pop;
  logic  q_ready;
  logic  q_valid;
  qent_t push_ent;
  qent_t pop_ent;

  necir_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .q_ready   (q_ready),
    .push      (push),
    .push_ent  (push_ent)
  );

  necir_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_ent (push_ent),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .pop_ent  (pop_ent)
  );

  necir_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .pop_ent   (pop_ent),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/core/necir_front.sv =====
// Front end: configuration registers and window classification of each edge.
module necir_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [necir_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  necir_pkg::in_item_t                  in_item,
  input  logic                                 q_ready,
  output logic                                 push,
  output necir_pkg::qent_t                     push_ent
);
  import necir_pkg::*;

  logic [15:0] start_min;
  logic [15:0] start_max;
  logic [15:0] repeat_min;
  logic [15:0] repeat_max;
  logic [15:0] bit_min;
  logic [15:0] bit_max;
  logic [15:0] one_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_min     <= 16'd1200;
      start_max     <= 16'd1500;
      repeat_min    <= 16'd1050;
      repeat_max    <= 16'd1180;
      bit_min       <= 16'd80;
      bit_max       <= 16'd280;
      one_threshold <= 16'd160;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_MIN:  start_min     <= cfg_data;
        CFG_START_MAX:  start_max     <= cfg_data;
        CFG_REPEAT_MIN: repeat_min    <= cfg_data;
        CFG_REPEAT_MAX: repeat_max    <= cfg_data;
        CFG_BIT_MIN:    bit_min       <= cfg_data;
        CFG_BIT_MAX:    bit_max       <= cfg_data;
        CFG_ONE_THRESH: one_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [15:0] iv;
  assign iv = in_item.interval;

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

  always_comb begin
    push_ent.timestamp      = in_item.timestamp;
    push_ent.cls.hold_hit   = (iv > HOLD_LOW) && (iv < HOLD_HIGH);
    push_ent.cls.start_hit  = (iv > start_min) && (iv < start_max);
    push_ent.cls.repeat_hit = (iv > repeat_min) && (iv < repeat_max);
    push_ent.cls.bit_bad    = (iv < bit_min) || (iv > bit_max);
    push_ent.cls.one_bit    = iv > one_threshold;
  end

endmodule

// ===== rtl/core/necir_queue.sv =====
// Two-entry queue of classified edges between front and back end.
module necir_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  necir_pkg::qent_t push_ent,
  output logic             q_ready,
  input  logic             pop,
  output logic             q_valid,
  output necir_pkg::qent_t pop_ent
);
  import necir_pkg::*;

  qent_t       ent [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign q_ready = count != 2'd2;
  assign q_valid = count != 2'd0;
  assign pop_ent = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/necir_back.sv =====
// Back end: frame state machine, hold counter and registered result.
module necir_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  necir_pkg::qent_t     pop_ent,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output necir_pkg::out_item_t out_item
);
  import necir_pkg::*;

  `include "nec_ir_edge_interval_decoder_defines.svh"

  logic             in_data;
  logic [CNT_W-1:0] bits_taken;
  logic [31:0]      shift_word;
  logic [15:0]      holds;
  logic [15:0]      last_hold;

  logic             in_data_next;
  logic [CNT_W-1:0] bits_taken_next;
  logic [31:0]      shift_word_next;
  logic [15:0]      holds_next;
  logic [15:0]      last_hold_next;
  logic [1:0]       ev;
  logic [31:0]      word;
  logic [31:0]      shifted;
  edge_class_t      cls;

  assign cls     = pop_ent.cls;
  assign pop     = q_valid && (!out_valid || out_ready);
  assign shifted = {cls.one_bit, shift_word[31:1]};

  always_comb begin
    in_data_next    = in_data;
    bits_taken_next = bits_taken;
    shift_word_next = shift_word;
    holds_next      = holds;
    last_hold_next  = last_hold;
    ev              = EV_NONE;
    word            = '0;
    if (!in_data) begin
      if (cls.hold_hit) begin
        holds_next     = holds + 16'd1;
        last_hold_next = pop_ent.timestamp;
      end
      if (cls.start_hit) begin
        in_data_next    = 1'b1;
        bits_taken_next = '0;
        shift_word_next = '0;
      end else if (cls.repeat_hit) begin
        ev = EV_REPEAT;
      end
    end else if (cls.bit_bad) begin
      in_data_next = 1'b0;
      ev           = EV_ABORT;
    end else begin
      shift_word_next = shifted;
      bits_taken_next = bits_taken + CNT_W'(1);
      if (bits_taken == CNT_W'(FRAME_BITS - 1)) begin
        in_data_next = 1'b0;
        ev           = EV_FRAME;
        word         = shifted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_data    <= 1'b0;
      bits_taken <= '0;
      shift_word <= '0;
      holds      <= '0;
      last_hold  <= '0;
      out_valid  <= 1'b0;
    end else if (pop) begin
      in_data    <= in_data_next;
      bits_taken <= bits_taken_next;
      shift_word <= shift_word_next;
      holds      <= holds_next;
      last_hold  <= last_hold_next;
      out_valid  <= 1'b1;
    end else if (out_ready) begin
      out_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item.event_res  <= ev;
      out_item.frame_word <= word;
      out_item.hold_count <= holds_next;
      out_item.hold_time  <= last_hold_next;
    end
  end

  `NECIR_ASSERT_NOW(a_word_only_on_frame,
    out_valid && (out_item.event_res != EV_FRAME), out_item.frame_word == 32'd0,
    "frame word nonzero on a non-frame event")
  `NECIR_ASSERT_NEXT(a_hold_step,
    pop && !in_data && cls.hold_hit, holds == $past(holds) + 16'd1,
    "hold counter did not advance by one")
  `NECIR_ASSERT_NOW(a_leave_data_reports,
    $fell(in_data) && !$past(rst),
    out_valid && ((out_item.event_res == EV_ABORT) || (out_item.event_res == EV_FRAME)),
    "data phase left without a frame or abort event")

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the NEC IR edge interval decoder: a predictor of the decoded events and
// hold counters, with random edge traffic, configuration changes and handshake stalls.
`timescale 1ns / 1ps

module tb_top;
  import necir_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 200;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_item;

  nec_ir_edge_interval_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  class ir_event_board;
    logic [15:0] start_min, start_max, repeat_min, repeat_max;
    logic [15:0] bit_min, bit_max, one_threshold;
    logic        in_data;
    logic [5:0]  bits_taken;
    logic [31:0] shift_word;
    logic [15:0] holds;
    logic [15:0] last_hold;
    out_item_t   due_results[$];
    int          errors;

    function new();
      start_min     = 16'd1200;
      start_max     = 16'd1500;
      repeat_min    = 16'd1050;
      repeat_max    = 16'd1180;
      bit_min       = 16'd80;
      bit_max       = 16'd280;
      one_threshold = 16'd160;
      in_data       = 1'b0;
      bits_taken    = '0;
      shift_word    = '0;
      holds         = '0;
      last_hold     = '0;
      errors        = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
      case (idx)
        CFG_START_MIN:  start_min = v;
        CFG_START_MAX:  start_max = v;
        CFG_REPEAT_MIN: repeat_min = v;
        CFG_REPEAT_MAX: repeat_max = v;
        CFG_BIT_MIN:    bit_min = v;
        CFG_BIT_MAX:    bit_max = v;
        CFG_ONE_THRESH: one_threshold = v;
        default: ;
      endcase
    endfunction

    function void decode_edge(in_item_t it);
      out_item_t e;
      e = '0;
      e.event_res = EV_NONE;
      if (!in_data) begin
        if (it.interval > HOLD_LOW && it.interval < HOLD_HIGH) begin
          holds = holds + 16'd1;
          last_hold = it.timestamp;
        end
        if (it.interval > start_min && it.interval < start_max) begin
          in_data = 1'b1;
          bits_taken = '0;
          shift_word = '0;
        end else if (it.interval > repeat_min && it.interval < repeat_max) begin
          e.event_res = EV_REPEAT;
        end
      end else begin
        if (it.interval < bit_min || it.interval > bit_max) begin
          in_data = 1'b0;
          e.event_res = EV_ABORT;
        end else begin
          shift_word = {it.interval > one_threshold, shift_word[31:1]};
          bits_taken = bits_taken + 6'd1;
          if (bits_taken >= FRAME_BITS) begin
            in_data = 1'b0;
            e.event_res = EV_FRAME;
            e.frame_word = shift_word;
          end
        end
      end
      e.hold_count = holds;
      e.hold_time = last_hold;
      due_results.push_back(e);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (due_results.size() == 0) begin
        $display("%0t: result with nothing due: %h", $time, got);
        errors++;
        return;
      end
      e = due_results.pop_front();
      if (got.event_res !== e.event_res) begin
        $display("%0t: event_res exp %0d got %0d", $time, e.event_res, got.event_res);
        errors++;
      end
      if (got.frame_word !== e.frame_word) begin
        $display("%0t: frame_word exp %h got %h", $time, e.frame_word, got.frame_word);
        errors++;
      end
      if (got.hold_count !== e.hold_count) begin
        $display("%0t: hold_count exp %h got %h", $time, e.hold_count, got.hold_count);
        errors++;
      end
      if (got.hold_time !== e.hold_time) begin
        $display("%0t: hold_time exp %h got %h", $time, e.hold_time, got.hold_time);
        errors++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  ir_event_board board = new();

  logic send_quiet = 1'b0;
  logic recv_quiet = 1'b0;
  int   hold_off   = 0;
  int   cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  // result side
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        gap = hold_off;
        hold_off = 0;
      end else begin
        gap = recv_quiet ? 0 : $urandom_range(0, 8);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_result(out_item);
    end
  end

  task automatic send_iv(logic [15:0] iv, logic [15:0] ts);
    int gap;
    in_item_t it;
    it.interval = iv;
    it.timestamp = ts;
    @(negedge clk);
    gap = send_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    board.decode_edge(it);
  endtask

  task automatic finish_burst();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, v);
  endtask

  task automatic write_all(int sm, int sx, int rm, int rx, int bm, int bx, int ot);
    write_reg(CFG_START_MIN, sm[15:0]);
    write_reg(CFG_START_MAX, sx[15:0]);
    write_reg(CFG_REPEAT_MIN, rm[15:0]);
    write_reg(CFG_REPEAT_MAX, rx[15:0]);
    write_reg(CFG_BIT_MIN, bm[15:0]);
    write_reg(CFG_BIT_MAX, bx[15:0]);
    write_reg(CFG_ONE_THRESH, ot[15:0]);
    write_reg(CFG_UNUSED, 16'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] in_window(logic [15:0] lo, logic [15:0] hi);
    int l, h;
    l = lo;
    h = hi;
    if (h - l >= 2) return 16'($urandom_range(l + 1, h - 1));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] data_interval(bit one);
    int lo, hi, t, a, b;
    lo = board.bit_min;
    hi = board.bit_max;
    t = board.one_threshold;
    a = one ? ((t + 1 > lo) ? t + 1 : lo) : lo;
    b = one ? hi : ((t < hi) ? t : hi);
    if (a <= b) return 16'($urandom_range(a, b));
    if (lo <= hi) return 16'($urandom_range(lo, hi));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] bad_interval();
    int lo, hi, r;
    lo = board.bit_min;
    hi = board.bit_max;
    r = $urandom_range(0, 2);
    if (r == 0 && lo > 0) return 16'($urandom_range(0, lo - 1));
    if (r == 1 && hi < 65535) return 16'($urandom_range(hi + 1, 65535));
    return 16'($urandom_range(9501, 10299));
  endfunction

  task automatic send_mix(int n, bit quiet_all);
    int sent, r, k, cut;
    sent = 0;
    while (sent < n) begin
      send_quiet = quiet_all || ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        // well-formed frame, or one cut short by a bad interval
        cut = (r < 50) ? FRAME_BITS : $urandom_range(0, FRAME_BITS - 1);
        send_iv(in_window(board.start_min, board.start_max), 16'($urandom));
        sent++;
        for (k = 0; k < cut; k++) begin
          send_iv(data_interval(1'($urandom_range(0, 1))), 16'($urandom));
          sent++;
        end
        if (cut < FRAME_BITS) begin
          send_iv(bad_interval(), 16'($urandom));
          sent++;
        end
      end else if (r < 75) begin
        send_iv(in_window(board.repeat_min, board.repeat_max), 16'($urandom));
        sent++;
      end else if (r < 85) begin
        send_iv(16'($urandom_range(9501, 10299)), 16'($urandom));
        sent++;
      end else begin
        send_iv(16'($urandom), 16'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    int i, sm, rm, bm;
    int directed_iv [0:21];
    directed_iv = '{0, 65535, 1201, 80, 280, 160, 161, 79, 1499, 281, 1300, 9600,
                    1051, 1179, 1050, 1180, 1200, 1500, 9501, 10299, 9500, 10300};
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < 22; i++) begin
      send_iv(16'(directed_iv[i]), (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom));
    end
    send_mix(100, 1'b0);
    finish_burst();

    // hold gaps inside overlapping start and repeat windows, all data intervals valid
    recv_quiet = ($urandom_range(0, 2) == 0);
    write_all(9000, 11000, 8000, 12000, 0, 65535, 32767);
    send_mix(60, 1'b0);
    finish_burst();

    // widest start window, empty repeat window, inverted bit bounds
    recv_quiet = 1'b0;
    write_all(0, 65535, 0, 0, 65535, 0, 0);
    send_mix(40, 1'b0);
    finish_burst();

    recv_quiet = ($urandom_range(0, 2) == 0);
    write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_mix(40, 1'b0);
    finish_burst();

    // receiver stalls long while edges keep coming
    recv_quiet = 1'b1;
    write_all(1100, 1400, 1000, 1200, 100, 300, 65535);
    hold_off = LONG_HOLD;
    send_mix(50, 1'b1);
    finish_burst();

    for (i = 0; i < 2; i++) begin
      recv_quiet = (i == 1);
      sm = $urandom_range(500, 2000);
      rm = $urandom_range(500, 2000);
      bm = $urandom_range(0, 200);
      write_all(sm, sm + $urandom_range(2, 600), rm, rm + $urandom_range(2, 300),
                bm, bm + $urandom_range(0, 400), (i == 0) ? 0 : bm + $urandom_range(0, 400));
      send_mix(60, 1'b0);
      finish_burst();
    end

    // back to reset values
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    write_all(1200, 1500, 1050, 1180, 80, 280, 160);
    send_mix(20, 1'b0);
    finish_burst();

    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
